// ===== rtl/pdsd_pkg.sv =====
// Shared constants and types for the packed delta sample decoder.
// Used by the top level and its checker; has no dependencies.
package pdsd_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_REF   = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;

    localparam int SAMPLE_W   = 32;
    localparam int WIDTH_W    = 6;
    localparam int CFG_W      = 4;
    localparam int CHAN_W     = 3;
    localparam int OPC_W      = 2;
    localparam int S_TDATA_W  = 40;
    localparam int FCNT_W     = 6;
    localparam int AVAIL_W    = 7;

    typedef logic [SAMPLE_W-1:0]   word_t;
    typedef logic [2*SAMPLE_W-1:0] dword_t;

endpackage

// ===== rtl/pdsd_mod.sv =====
// Iterative remainder unit: one restoring subtract step per cycle.
// Recovers the channel phase from the sample count; no package dependency.
module pdsd_mod #(
    parameter int SC_W  = 11,
    parameter int NCH_W = 4,
    parameter int CH_W  = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SC_W-1:0]  dividend,
    input  logic [NCH_W-1:0] divisor,
    output logic             done,
    output logic [CH_W-1:0]  remainder
);

    localparam int STEP_W = $clog2(SC_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SC_W-1:0]   dvd_reg, dvd_next;
    logic [NCH_W-1:0]  rem_reg, rem_next;
    logic [NCH_W:0]    rem_sh;
    logic [NCH_W:0]    rem_sub;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg, dvd_reg[SC_W-1]};
        rem_sub   = rem_sh - {1'b0, divisor};
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(SC_W);
            dvd_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next  = dvd_reg << 1;
            rem_next  = (rem_sh >= {1'b0, divisor}) ? rem_sub[NCH_W-1:0]
                                                    : rem_sh[NCH_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = CH_W'(rem_reg);

endmodule

// ===== rtl/packed_delta_sample_decoder_top.sv =====
// Top level of the packed delta sample decoder.
// Depends on pdsd_pkg and instantiates the remainder unit pdsd_mod.
//
// Usage: beats on the s_ channel carry an opcode in s_tuser (block start,
// channel reference word, packed data word). A block start sets the field
// width; reference beats load one channel each; each data beat is then cut
// into fields that are sign-extended and accumulated per channel. Decoded
// samples leave on the m_ channel, one beat per field, with the channel in
// m_tuser and m_tlast on the final sample of the block.
// Start, reference and ignored beats leave s_tready high. A data beat holding
// N fields keeps s_tready low after acceptance while the field extractor
// issues one sample per cycle through the output register, as long as
// m_tready allows. After a write of cfg_wr_data, the next data beat first
// waits while the remainder unit recomputes the channel phase one bit per cycle.
// When m_tready is low the extractor pauses and the output beat holds.
// Reset clears the sequencer and the output valid; the channel count
// returns to one and no block is open.
module packed_delta_sample_decoder_top
    import pdsd_pkg::*;
#(
    parameter int SAMPLES_PER_BLOCK = 128,
    parameter int MAX_CHANNELS      = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,   // num_channels
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // data_word, sample_width, zero pad
    input  logic [OPC_W-1:0]     s_tuser,       // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [SAMPLE_W-1:0]  m_tdata,       // sample
    output logic [CHAN_W-1:0]    m_tuser,       // channel
    output logic                 m_tlast
);

    localparam int TOTAL_MAX = MAX_CHANNELS * SAMPLES_PER_BLOCK;
    localparam int SC_W      = $clog2(TOTAL_MAX + 1);
    localparam int NCH_W     = $clog2(MAX_CHANNELS + 1);
    localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOD  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [CFG_W-1:0]   ncfg_reg, ncfg_next;
    logic [WIDTH_W-1:0] fw_reg, fw_next;
    word_t              lo_bits_reg, lo_bits_next;
    logic [WIDTH_W-1:0] lo_cnt_reg, lo_cnt_next;
    logic [SC_W-1:0]    scnt_reg, scnt_next;
    logic [NCH_W-1:0]   rcnt_reg, rcnt_next;
    logic               active_reg, active_next;
    logic               stale_reg, stale_next;
    logic [CH_W-1:0]    ch_reg, ch_next;
    dword_t             buf_reg, buf_next;
    logic [AVAIL_W-1:0] avail_reg, avail_next;
    logic [FCNT_W-1:0]  fcnt_reg, fcnt_next;
    logic               mvalid_reg, mvalid_next;
    word_t              mdata_reg, mdata_next;
    logic [CHAN_W-1:0]  muser_reg, muser_next;
    logic               mlast_reg, mlast_next;

    word_t              prev_mem [MAX_CHANNELS];
    logic               mem_we;
    logic [CH_W-1:0]    mem_addr;
    word_t              mem_wdata;
    word_t              prev_rd;

    logic [NCH_W-1:0]   nch;
    logic [SC_W-1:0]    total;
    logic [WIDTH_W-1:0] sw_in;
    logic [WIDTH_W-1:0] sw_clamp;
    logic               in_acc;
    logic               out_free;
    logic [AVAIL_W-1:0] shamt;
    dword_t             shifted;
    word_t              fmask;
    word_t              field;
    word_t              sext;
    word_t              lmask;
    logic               can_emit;
    logic               is_ref;
    word_t              value;
    logic               last;
    logic [SC_W-1:0]    scnt_inc;
    logic               mod_start;
    logic               mod_done;
    logic [CH_W-1:0]    mod_rem;

    always_comb begin
        if (ncfg_reg == '0) begin
            nch = NCH_W'(1);
        end else if (32'(ncfg_reg) > MAX_CHANNELS) begin
            nch = NCH_W'(MAX_CHANNELS);
        end else begin
            nch = NCH_W'(ncfg_reg);
        end
    end

    assign total    = SC_W'(nch) * SC_W'(SAMPLES_PER_BLOCK);
    assign sw_in    = s_tdata[SAMPLE_W +: WIDTH_W];
    assign sw_clamp = (sw_in == '0) ? WIDTH_W'(1)
                    : ((sw_in > WIDTH_W'(32)) ? WIDTH_W'(32) : sw_in);

    assign s_tready = (state_reg == ST_IDLE) && aresetn;
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;

    assign shamt    = avail_reg - AVAIL_W'(fw_reg);
    assign shifted  = buf_reg >> shamt;
    assign fmask    = word_t'((33'd1 << fw_reg) - 33'd1);
    assign field    = shifted[SAMPLE_W-1:0] & fmask;
    assign sext     = ((fw_reg != WIDTH_W'(32)) && field[5'(fw_reg - WIDTH_W'(1))])
                    ? (field | ~fmask) : field;
    assign lmask    = (avail_reg[AVAIL_W-1:5] != '0) ? '1
                    : word_t'((33'd1 << avail_reg[4:0]) - 33'd1);
    assign can_emit = active_reg && (avail_reg >= AVAIL_W'(fw_reg))
                    && (fcnt_reg < FCNT_W'(32));

    assign prev_rd  = prev_mem[ch_reg];
    assign is_ref   = scnt_reg < SC_W'(nch);
    assign value    = is_ref ? prev_rd : (prev_rd + sext);
    assign scnt_inc = scnt_reg + SC_W'(1);
    assign last     = scnt_inc >= total;

    always_comb begin
        state_next   = state_reg;
        ncfg_next    = ncfg_reg;
        fw_next      = fw_reg;
        lo_bits_next = lo_bits_reg;
        lo_cnt_next  = lo_cnt_reg;
        scnt_next    = scnt_reg;
        rcnt_next    = rcnt_reg;
        active_next  = active_reg;
        stale_next   = stale_reg;
        ch_next      = ch_reg;
        buf_next     = buf_reg;
        avail_next   = avail_reg;
        fcnt_next    = fcnt_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        mdata_next   = mdata_reg;
        muser_next   = muser_reg;
        mlast_next   = mlast_reg;
        mem_we       = 1'b0;
        mem_addr     = ch_reg;
        mem_wdata    = value;
        mod_start    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    case (s_tuser)
                        OP_START: begin
                            fw_next      = sw_clamp;
                            lo_bits_next = '0;
                            lo_cnt_next  = '0;
                            scnt_next    = '0;
                            rcnt_next    = '0;
                            active_next  = 1'b1;
                            ch_next      = '0;
                            stale_next   = 1'b0;
                        end
                        OP_REF: begin
                            if (active_reg && (rcnt_reg < nch)) begin
                                mem_we    = 1'b1;
                                mem_addr  = CH_W'(rcnt_reg);
                                mem_wdata = s_tdata[SAMPLE_W-1:0];
                                rcnt_next = rcnt_reg + NCH_W'(1);
                            end
                        end
                        OP_DATA: begin
                            if (active_reg && (rcnt_reg >= nch)) begin
                                buf_next   = {lo_bits_reg, s_tdata[SAMPLE_W-1:0]};
                                avail_next = AVAIL_W'(lo_cnt_reg) + AVAIL_W'(32);
                                fcnt_next  = '0;
                                if (stale_reg) begin
                                    mod_start  = 1'b1;
                                    state_next = ST_MOD;
                                end else begin
                                    state_next = ST_RUN;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    ch_next    = mod_rem;
                    stale_next = 1'b0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (can_emit) begin
                    if (out_free) begin
                        mvalid_next = 1'b1;
                        mdata_next  = value;
                        muser_next  = CHAN_W'({{CHAN_W{1'b0}}, ch_reg});
                        mlast_next  = last;
                        mem_we      = !is_ref;
                        scnt_next   = scnt_inc;
                        ch_next     = (NCH_W'(ch_reg) == nch - NCH_W'(1))
                                    ? '0 : ch_reg + CH_W'(1);
                        avail_next  = avail_reg - AVAIL_W'(fw_reg);
                        fcnt_next   = fcnt_reg + FCNT_W'(1);
                        if (last) begin
                            active_next = 1'b0;
                        end
                    end
                end else begin
                    if (active_reg) begin
                        lo_cnt_next  = avail_reg[WIDTH_W-1:0];
                        lo_bits_next = buf_reg[SAMPLE_W-1:0] & lmask;
                    end else begin
                        lo_cnt_next  = '0;
                        lo_bits_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            ncfg_next  = cfg_wr_data;
            stale_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ncfg_reg    <= CFG_W'(1);
            fw_reg      <= WIDTH_W'(1);
            lo_bits_reg <= '0;
            lo_cnt_reg  <= '0;
            scnt_reg    <= '0;
            rcnt_reg    <= '0;
            active_reg  <= 1'b0;
            stale_reg   <= 1'b0;
            ch_reg      <= '0;
            mvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ncfg_reg    <= ncfg_next;
            fw_reg      <= fw_next;
            lo_bits_reg <= lo_bits_next;
            lo_cnt_reg  <= lo_cnt_next;
            scnt_reg    <= scnt_next;
            rcnt_reg    <= rcnt_next;
            active_reg  <= active_next;
            stale_reg   <= stale_next;
            ch_reg      <= ch_next;
            mvalid_reg  <= mvalid_next;
        end
        buf_reg   <= buf_next;
        avail_reg <= avail_next;
        fcnt_reg  <= fcnt_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
        mlast_reg <= mlast_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            prev_mem[mem_addr] <= mem_wdata;
        end
    end

    pdsd_mod #(
        .SC_W  (SC_W),
        .NCH_W (NCH_W),
        .CH_W  (CH_W)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (scnt_reg),
        .divisor   (nch),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;
    assign m_tlast  = mlast_reg;

endmodule

// ===== rtl/pdsd_checker.sv =====
// Port-level checker for the packed delta sample decoder, bound to the top.
// Depends on pdsd_pkg for opcodes and port widths.
module pdsd_checker
    import pdsd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [OPC_W-1:0]     s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [SAMPLE_W-1:0]  m_tdata,
    input logic [CHAN_W-1:0]    m_tuser,
    input logic                 m_tlast
);

    // The output channel comes out of reset empty.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output beat valid right after reset");

    // A stalled output beat keeps its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled output beat changed");

    // Only data beats start the extractor, so other beats leave the input ready.
    a_ctrl_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != OP_DATA |=> s_tready)
        else $error("input not ready after a control beat");

    // A block start produces no sample beat of its own.
    a_start_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_START |=> !$rose(m_tvalid))
        else $error("sample beat raised by a block start");

endmodule

bind packed_delta_sample_decoder_top pdsd_checker u_pdsd_checker (.*);
